// ===== src/msns_pkg.sv =====
// Shared constants, register codes and pipeline depths for the mass-spring node step.
package msns_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 27;

	localparam int unsigned REST_W  = 27;
	localparam int unsigned COEF_W  = 17;
	localparam int unsigned SLIM_W  = 23;

	localparam logic [REST_W-1:0] REST_RST  = 27'd655360;
	localparam logic [COEF_W-1:0] STIFF_RST = 17'd19661;
	localparam logic [COEF_W-1:0] GRAV_RST  = 17'd655;
	localparam logic [COEF_W-1:0] DAMP_RST  = 17'd393;
	localparam logic [SLIM_W-1:0] SLIM_RST  = 23'd327680;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REST_LENGTH = 3'd0,
		CFG_STIFFNESS   = 3'd1,
		CFG_GRAVITY     = 3'd2,
		CFG_DAMPING     = 3'd3,
		CFG_SPEED_LIMIT = 3'd4
	} cfg_idx_t;

	// root/divide unit: 2 entry stages, one root bit and one quotient bit per stage
	localparam int unsigned NSQ_STEPS = 33;
	localparam int unsigned NDV_STEPS = 31;
	localparam int unsigned NDIV_LAT  = NSQ_STEPS + NDV_STEPS + 2;

	// spring pull clamp, +-2^32
	localparam logic signed [52:0] S_HI = 53'sd4294967296;
	localparam logic signed [52:0] S_LO = -53'sd4294967296;

	// 32-bit saturation bounds on a 40-bit working value
	localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
	localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

	// largest unit-vector component, 2^30
	localparam logic [30:0] UNIT_ONE = 31'd1073741824;

endpackage

// ===== src/msns_if.sv =====
// Valid/ready channels carrying one node beat in and one updated node beat out.
interface msns_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] nb1_x;
	logic signed [31:0] nb1_y;
	logic signed [31:0] nb2_x;
	logic signed [31:0] nb2_y;
	logic signed [31:0] nb3_x;
	logic signed [31:0] nb3_y;
	logic signed [31:0] nb4_x;
	logic signed [31:0] nb4_y;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, nb1_x, nb1_y, nb2_x, nb2_y,
		nb3_x, nb3_y, nb4_x, nb4_y, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, nb1_x, nb1_y, nb2_x, nb2_y,
		nb3_x, nb3_y, nb4_x, nb4_y, output ready);
endinterface

interface msns_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] new_pos_x;
	logic signed [31:0] new_pos_y;
	logic signed [31:0] new_vel_x;
	logic signed [31:0] new_vel_y;

	modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, input ready);
	modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, output ready);
endinterface

// ===== src/mass_spring_node_step.sv =====
// One explicit-Euler cloth node update: four springs, gravity, speed limit, damping, move.
//
//  channel    dir  beat contents                                       handshake
//  node_in    in   pos, vel, four neighbor positions (Q16.16)          valid/ready
//  node_out   out  new_pos, new_vel (Q16.16, saturated)                valid/ready
//  cfg        in   rest_length, stiffness, gravity, damping, limit     cfg_we only
//
// Takes one beat per cycle while the skid stage is empty. Most of the pipeline depth
// lies in two root/divide steps in series (spring lanes, then speed), each 33 root stages plus 31 quotient stages.
// arst_n clears the valid bits, including the output and skid flags, and loads register defaults.
// A stalled output beat is held and the next one drops into a skid stage; ready falls
// only while the skid stage is full, and the whole pipeline then holds in place.
module mass_spring_node_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [msns_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [msns_pkg::CFG_DATA_W-1:0]  cfg_data,
	msns_in_if.sink                           node_in,
	msns_out_if.source                        node_out
);

	localparam int unsigned LAT = msns_pkg::NDIV_LAT;

	typedef struct packed {
		logic               vld;
		logic [3:0]         sgx;
		logic [3:0]         sgy;
		logic [3:0]         coin;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
	} lsb_t;

	typedef struct packed {
		logic               vld;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] px;
		logic signed [31:0] py;
	} ssb_t;

	typedef struct packed {
		logic signed [31:0] npx;
		logic signed [31:0] npy;
		logic signed [31:0] nvx;
		logic signed [31:0] nvy;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > msns_pkg::SAT_HI) return 32'sh7FFFFFFF;
		if (v < msns_pkg::SAT_LO) return 32'sh80000000;
		return v[31:0];
	endfunction

	// configuration registers
	logic [msns_pkg::REST_W-1:0] rest_q;
	logic [msns_pkg::COEF_W-1:0] stiff_q;
	logic [msns_pkg::COEF_W-1:0] grav_q;
	logic [msns_pkg::COEF_W-1:0] damp_q;
	logic [msns_pkg::SLIM_W-1:0] slim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= msns_pkg::REST_RST;
			stiff_q <= msns_pkg::STIFF_RST;
			grav_q <= msns_pkg::GRAV_RST;
			damp_q <= msns_pkg::DAMP_RST;
			slim_q <= msns_pkg::SLIM_RST;
		end else if (cfg_we) begin
			case (msns_pkg::cfg_idx_t'(cfg_idx))
				msns_pkg::CFG_REST_LENGTH: rest_q <= cfg_data;
				msns_pkg::CFG_STIFFNESS:   stiff_q <= cfg_data[msns_pkg::COEF_W-1:0];
				msns_pkg::CFG_GRAVITY:     grav_q <= cfg_data[msns_pkg::COEF_W-1:0];
				msns_pkg::CFG_DAMPING:     damp_q <= cfg_data[msns_pkg::COEF_W-1:0];
				msns_pkg::CFG_SPEED_LIMIT: slim_q <= cfg_data[msns_pkg::SLIM_W-1:0];
				default: ;  // unknown index: drop the write
			endcase
		end
	end

	// flow control: everything advances unless the skid stage is occupied
	logic adv;
	logic acc;
	logic o_v_q;
	logic sk_v_q;
	res_t o_q;
	res_t sk_q;

	assign adv = !sk_v_q;
	assign acc = node_in.valid && adv;
	assign node_in.ready = adv;

	// stage 1: neighbor offsets, their magnitudes and signs
	logic signed [31:0] nbx [0:3];
	logic signed [31:0] nby [0:3];
	logic [32:0]        dx1 [0:3];
	logic [32:0]        dy1 [0:3];
	logic [32:0]        adx1 [0:3];
	logic [32:0]        ady1 [0:3];
	lsb_t               lsb1;

	always_comb begin
		nbx[0] = node_in.nb1_x;
		nby[0] = node_in.nb1_y;
		nbx[1] = node_in.nb2_x;
		nby[1] = node_in.nb2_y;
		nbx[2] = node_in.nb3_x;
		nby[2] = node_in.nb3_y;
		nbx[3] = node_in.nb4_x;
		nby[3] = node_in.nb4_y;
		lsb1.vld = acc;
		lsb1.px = node_in.pos_x;
		lsb1.py = node_in.pos_y;
		lsb1.vx = node_in.vel_x;
		lsb1.vy = node_in.vel_y;
		for (int k = 0; k < 4; k++) begin
			dx1[k] = {node_in.pos_x[31], node_in.pos_x} - {nbx[k][31], nbx[k]};
			dy1[k] = {node_in.pos_y[31], node_in.pos_y} - {nby[k][31], nby[k]};
			adx1[k] = dx1[k][32] ? (~dx1[k] + 33'd1) : dx1[k];
			ady1[k] = dy1[k][32] ? (~dy1[k] + 33'd1) : dy1[k];
			lsb1.sgx[k] = dx1[k][32];
			lsb1.sgy[k] = dy1[k][32];
			// a neighbor sitting on the node pulls nothing
			lsb1.coin[k] = (dx1[k] == 33'd0) && (dy1[k] == 33'd0);
		end
	end

	logic [32:0] adx_s1 [0:3];
	logic [32:0] ady_s1 [0:3];
	lsb_t        lsb_s1;

	// spring lanes: length and unit direction (scaled by 2^30) per neighbor
	logic [32:0] len_l [0:3];
	logic [30:0] qx_l [0:3];
	logic [30:0] qy_l [0:3];

	for (genvar k = 0; k < 4; k++) begin : g_lane
		msns_normdiv u_nd (
			.clk    (clk),
			.en     (adv),
			.a      (adx_s1[k]),
			.b      (ady_s1[k]),
			.na     ({adx_s1[k], 30'd0}),
			.nb     ({ady_s1[k], 30'd0}),
			.root   (len_l[k]),
			.rem_nz (),
			.qa     (qx_l[k]),
			.qb     (qy_l[k])
		);
	end

	lsb_t lsb_dl [0:LAT-1];
	lsb_t lsb_at;
	assign lsb_at = lsb_dl[LAT-1];

	// stage 2: spring pull product and signed direction
	logic signed [34:0] diff2 [0:3];
	logic signed [52:0] prod2 [0:3];
	logic signed [31:0] tx2 [0:3];
	logic signed [31:0] ty2 [0:3];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			diff2[k] = $signed({8'd0, rest_q}) - $signed({2'd0, len_l[k]});
			prod2[k] = $signed({1'b0, stiff_q}) * diff2[k];
			tx2[k] = lsb_at.sgx[k] ? $signed(~{1'b0, qx_l[k]} + 32'd1) : $signed({1'b0, qx_l[k]});
			ty2[k] = lsb_at.sgy[k] ? $signed(~{1'b0, qy_l[k]} + 32'd1) : $signed({1'b0, qy_l[k]});
		end
	end

	logic signed [52:0] p_s2 [0:3];
	logic signed [31:0] tx_s2 [0:3];
	logic signed [31:0] ty_s2 [0:3];
	lsb_t               lsb_s2;

	// stage 3: scale down and clamp the pull
	logic signed [52:0] sh3 [0:3];
	logic signed [33:0] s3 [0:3];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sh3[k] = p_s2[k] >>> 16;
			if (sh3[k] > msns_pkg::S_HI) begin
				s3[k] = msns_pkg::S_HI[33:0];
			end else if (sh3[k] < msns_pkg::S_LO) begin
				s3[k] = msns_pkg::S_LO[33:0];
			end else begin
				s3[k] = sh3[k][33:0];
			end
		end
	end

	logic signed [33:0] s_s3 [0:3];
	logic signed [31:0] tx_s3 [0:3];
	logic signed [31:0] ty_s3 [0:3];
	lsb_t               lsb_s3;

	// stage 4: force components before the final scale
	logic signed [65:0] st4x [0:3];
	logic signed [65:0] st4y [0:3];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			st4x[k] = s_s3[k] * tx_s3[k];
			st4y[k] = s_s3[k] * ty_s3[k];
		end
	end

	logic signed [65:0] stx_s4 [0:3];
	logic signed [65:0] sty_s4 [0:3];
	lsb_t               lsb_s4;

	// stage 5: floor by 2^30, drop coincident neighbors
	logic signed [33:0] tr5x [0:3];
	logic signed [33:0] tr5y [0:3];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			tr5x[k] = lsb_s4.coin[k] ? 34'sd0 : stx_s4[k][63:30];
			tr5y[k] = lsb_s4.coin[k] ? 34'sd0 : sty_s4[k][63:30];
		end
	end

	logic signed [33:0] trx_s5 [0:3];
	logic signed [33:0] try_s5 [0:3];
	lsb_t               lsb_s5;

	// stage 6: total force
	logic signed [35:0] f6x;
	logic signed [35:0] f6y;

	always_comb begin
		f6x = '0;
		f6y = '0;
		for (int k = 0; k < 4; k++) begin
			f6x = f6x + {{2{trx_s5[k][33]}}, trx_s5[k]};
			f6y = f6y + {{2{try_s5[k][33]}}, try_s5[k]};
		end
	end

	logic signed [35:0] fx_s6;
	logic signed [35:0] fy_s6;
	lsb_t               lsb_s6;

	// stage 7: velocity after forces and gravity
	ssb_t ssb7;

	always_comb begin
		ssb7.vld = lsb_s6.vld;
		ssb7.px = lsb_s6.px;
		ssb7.py = lsb_s6.py;
		ssb7.vx = sat32({{8{lsb_s6.vx[31]}}, lsb_s6.vx} + {{4{fx_s6[35]}}, fx_s6});
		ssb7.vy = sat32({{8{lsb_s6.vy[31]}}, lsb_s6.vy} + {{4{fy_s6[35]}}, fy_s6}
			- {23'd0, grav_q});
	end

	ssb_t ssb_s7;

	// stage 8: speed magnitudes; feed the speed root/divide unit
	logic [31:0] av8x;
	logic [31:0] av8y;

	assign av8x = ssb_s7.vx[31] ? (~ssb_s7.vx + 32'd1) : ssb_s7.vx;
	assign av8y = ssb_s7.vy[31] ? (~ssb_s7.vy + 32'd1) : ssb_s7.vy;

	logic [31:0] avx_s8;
	logic [31:0] avy_s8;
	ssb_t        ssb_s8;
	logic [54:0] nmx;
	logic [54:0] nmy;

	assign nmx = avx_s8 * slim_q;
	assign nmy = avy_s8 * slim_q;

	logic [32:0] root_sp;
	logic        rnz_sp;
	logic [30:0] qsx;
	logic [30:0] qsy;

	msns_normdiv u_speed (
		.clk    (clk),
		.en     (adv),
		.a      ({1'b0, avx_s8}),
		.b      ({1'b0, avy_s8}),
		.na     ({8'd0, nmx}),
		.nb     ({8'd0, nmy}),
		.root   (root_sp),
		.rem_nz (rnz_sp),
		.qa     (qsx),
		.qb     (qsy)
	);

	ssb_t ssb_dl [0:LAT-1];
	ssb_t ssb_at;
	assign ssb_at = ssb_dl[LAT-1];

	// stage 9: speed limit; v^2 > lim^2 exactly when root > lim, or root == lim with
	// a nonzero remainder
	logic lim9;
	ssb_t ssb9;

	always_comb begin
		lim9 = (root_sp > {10'd0, slim_q}) || ((root_sp == {10'd0, slim_q}) && rnz_sp);
		ssb9 = ssb_at;
		if (lim9) begin
			ssb9.vx = ssb_at.vx[31] ? $signed(~{1'b0, qsx} + 32'd1) : $signed({1'b0, qsx});
			ssb9.vy = ssb_at.vy[31] ? $signed(~{1'b0, qsy} + 32'd1) : $signed({1'b0, qsy});
		end
	end

	ssb_t ssb_s9;

	// stage 10: damping product
	logic signed [49:0] dm10x;
	logic signed [49:0] dm10y;

	assign dm10x = $signed({1'b0, damp_q}) * ssb_s9.vx;
	assign dm10y = $signed({1'b0, damp_q}) * ssb_s9.vy;

	logic signed [49:0] dmx_s10;
	logic signed [49:0] dmy_s10;
	ssb_t               ssb_s10;

	// stage 11: damped velocity
	ssb_t ssb11;

	always_comb begin
		ssb11 = ssb_s10;
		ssb11.vx = sat32({{8{ssb_s10.vx[31]}}, ssb_s10.vx}
			- {{6{dmx_s10[49]}}, dmx_s10[49:16]});
		ssb11.vy = sat32({{8{ssb_s10.vy[31]}}, ssb_s10.vy}
			- {{6{dmy_s10[49]}}, dmy_s10[49:16]});
	end

	ssb_t ssb_s11;
	res_t fin;

	// move the node
	always_comb begin
		fin.npx = sat32({{8{ssb_s11.px[31]}}, ssb_s11.px} + {{8{ssb_s11.vx[31]}}, ssb_s11.vx});
		fin.npy = sat32({{8{ssb_s11.py[31]}}, ssb_s11.py} + {{8{ssb_s11.vy[31]}}, ssb_s11.vy});
		fin.nvx = ssb_s11.vx;
		fin.nvy = ssb_s11.vy;
	end

	// sideband and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsb_s1 <= '0;
			for (int i = 0; i < LAT; i++) begin
				lsb_dl[i] <= '0;
				ssb_dl[i] <= '0;
			end
			lsb_s2 <= '0;
			lsb_s3 <= '0;
			lsb_s4 <= '0;
			lsb_s5 <= '0;
			lsb_s6 <= '0;
			ssb_s7 <= '0;
			ssb_s8 <= '0;
			ssb_s9 <= '0;
			ssb_s10 <= '0;
			ssb_s11 <= '0;
		end else if (adv) begin
			lsb_s1 <= lsb1;
			lsb_dl[0] <= lsb_s1;
			ssb_dl[0] <= ssb_s8;
			for (int i = 1; i < LAT; i++) begin
				lsb_dl[i] <= lsb_dl[i-1];
				ssb_dl[i] <= ssb_dl[i-1];
			end
			lsb_s2 <= lsb_at;
			lsb_s3 <= lsb_s2;
			lsb_s4 <= lsb_s3;
			lsb_s5 <= lsb_s4;
			lsb_s6 <= lsb_s5;
			ssb_s7 <= ssb7;
			ssb_s8 <= ssb_s7;
			ssb_s9 <= ssb9;
			ssb_s10 <= ssb_s9;
			ssb_s11 <= ssb11;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				adx_s1[k] <= adx1[k];
				ady_s1[k] <= ady1[k];
				p_s2[k] <= prod2[k];
				tx_s2[k] <= tx2[k];
				ty_s2[k] <= ty2[k];
				s_s3[k] <= s3[k];
				tx_s3[k] <= tx_s2[k];
				ty_s3[k] <= ty_s2[k];
				stx_s4[k] <= st4x[k];
				sty_s4[k] <= st4y[k];
				trx_s5[k] <= tr5x[k];
				try_s5[k] <= tr5y[k];
			end
			fx_s6 <= f6x;
			fy_s6 <= f6y;
			avx_s8 <= av8x;
			avy_s8 <= av8y;
			dmx_s10 <= dm10x;
			dmy_s10 <= dm10y;
		end
	end

	// output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (!o_v_q || node_out.ready) begin
			if (sk_v_q) begin
				o_v_q <= 1'b1;
				sk_v_q <= 1'b0;
			end else begin
				o_v_q <= ssb_s11.vld;
			end
		end else if (adv && ssb_s11.vld) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_v_q || node_out.ready) begin
			o_q <= sk_v_q ? sk_q : fin;
		end
		if (o_v_q && !node_out.ready && adv) begin
			sk_q <= fin;
		end
	end

	assign node_out.valid     = o_v_q;
	assign node_out.new_pos_x = o_q.npx;
	assign node_out.new_pos_y = o_q.npy;
	assign node_out.new_vel_x = o_q.nvx;
	assign node_out.new_vel_y = o_q.nvy;

	// a direction component can never exceed one unit
	logic lane_q_over;

	always_comb begin
		lane_q_over = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (!lsb_at.coin[k] && ((qx_l[k] > msns_pkg::UNIT_ONE)
				|| (qy_l[k] > msns_pkg::UNIT_ONE))) begin
				lane_q_over = 1'b1;
			end
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> o_v_q)
		else $error("skid stage full while output stage empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(o_v_q && !node_out.ready))
		else $error("skid stage filled without an output stall");

	a_lane_unit: assert property (@(posedge clk) disable iff (!arst_n)
		lsb_at.vld |-> !lane_q_over)
		else $error("spring direction component above one");

	a_speed_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(ssb_at.vld && lim9) |-> ((qsx <= {8'd0, slim_q}) && (qsy <= {8'd0, slim_q})))
		else $error("limited velocity component above speed limit");

endmodule

// ===== src/msns_normdiv.sv =====
// Pipelined floor(sqrt(a^2+b^2)) followed by two dividers sharing that root.
module msns_normdiv (
	input  logic        clk,
	input  logic        en,
	input  logic [32:0] a,
	input  logic [32:0] b,
	input  logic [62:0] na,
	input  logic [62:0] nb,
	output logic [32:0] root,
	output logic        rem_nz,
	output logic [30:0] qa,
	output logic [30:0] qb
);

	typedef struct packed {
		logic [65:0] x;
		logic [32:0] r;
		logic [35:0] rem;
		logic [62:0] na;
		logic [62:0] nb;
	} sq_t;

	typedef struct packed {
		logic [32:0] root;
		logic        rnz;
		logic [32:0] ra;
		logic [32:0] rb;
		logic [30:0] nqa;
		logic [30:0] nqb;
	} dv_t;

	// one root bit: bring down two radicand bits, try (2r)*2+1
	function automatic sq_t sq_step(input sq_t s);
		sq_t o;
		logic [35:0] t;
		logic [35:0] trial;
		o = s;
		t = {s.rem[33:0], s.x[65:64]};
		trial = {1'b0, s.r, 2'b01};
		o.x = {s.x[63:0], 2'b00};
		if (t >= trial) begin
			o.rem = t - trial;
			o.r = {s.r[31:0], 1'b1};
		end else begin
			o.rem = t;
			o.r = {s.r[31:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit; remainder and numerator/quotient shift word
	function automatic logic [63:0] div_bit(input logic [32:0] rem, input logic [30:0] nq,
		input logic [32:0] d);
		logic [33:0] t;
		logic [33:0] diff;
		logic        ge;
		t = {rem, nq[30]};
		diff = t - {1'b0, d};
		ge = (t >= {1'b0, d});
		return {(ge ? diff[32:0] : t[32:0]), nq[29:0], ge};
	endfunction

	// top 32 numerator bits seed the remainder: quotient fits 31 bits
	function automatic dv_t dv_init(input sq_t s);
		dv_t o;
		o.root = s.r;
		o.rnz = |s.rem;
		o.ra = {1'b0, s.na[62:31]};
		o.rb = {1'b0, s.nb[62:31]};
		o.nqa = s.na[30:0];
		o.nqb = s.nb[30:0];
		return o;
	endfunction

	function automatic dv_t dv_step(input dv_t s);
		dv_t o;
		o = s;
		{o.ra, o.nqa} = div_bit(s.ra, s.nqa, s.root);
		{o.rb, o.nqb} = div_bit(s.rb, s.nqb, s.root);
		return o;
	endfunction

	logic [65:0] sqa_s1;
	logic [65:0] sqb_s1;
	logic [62:0] na_s1;
	logic [62:0] nb_s1;
	sq_t         sq_s [0:msns_pkg::NSQ_STEPS];
	dv_t         dv_s [1:msns_pkg::NDV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s1 <= a * a;
			sqb_s1 <= b * b;
			na_s1 <= na;
			nb_s1 <= nb;
			sq_s[0].x <= sqa_s1 + sqb_s1;
			sq_s[0].r <= '0;
			sq_s[0].rem <= '0;
			sq_s[0].na <= na_s1;
			sq_s[0].nb <= nb_s1;
			for (int i = 1; i <= msns_pkg::NSQ_STEPS; i++) begin
				sq_s[i] <= sq_step(sq_s[i-1]);
			end
			dv_s[1] <= dv_step(dv_init(sq_s[msns_pkg::NSQ_STEPS]));
			for (int j = 2; j <= msns_pkg::NDV_STEPS; j++) begin
				dv_s[j] <= dv_step(dv_s[j-1]);
			end
		end
	end

	assign root   = dv_s[msns_pkg::NDV_STEPS].root;
	assign rem_nz = dv_s[msns_pkg::NDV_STEPS].rnz;
	assign qa     = dv_s[msns_pkg::NDV_STEPS].nqa;
	assign qb     = dv_s[msns_pkg::NDV_STEPS].nqb;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the mass-spring node step: random and directed node beats.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [msns_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
	localparam int unsigned RUN_LIMIT = 600000;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam longint SPRING_CLAMP = 64'sd4294967296;

	typedef logic [msns_pkg::CFG_DATA_W-1:0] cfg_word_t;

	// Idle modes for the two sides of the block.
	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
		logic signed [31:0] nb_x [4];
		logic signed [31:0] nb_y [4];
	} node_beat_t;

	typedef struct {
		logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
	} node_update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [msns_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [msns_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	msns_in_if node_in ();
	msns_out_if node_out ();

	mass_spring_node_step uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.node_in (node_in.sink),
		.node_out(node_out.source)
	);

	always #5 clk = ~clk;

	// Mirror of the block's registers, updated as each register write goes out.
	longint rest_len_m, stiff_m, grav_m, damp_m, slim_m;

	node_beat_t   beats_waiting[$];
	node_update_t updates_due[$];
	node_beat_t   beat_on_bus;
	idle_mode_t   idle_mode = IDLE_NONE;
	int           errors = 0;
	logic         hold_req = 1'b0;
	int unsigned  hold_left = 0;
	int unsigned  cycle_cnt = 0;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Floor square root of a value below 2^66, one bit at a time.
	function automatic longint floor_root(logic [65:0] s);
		logic [32:0] r, c;
		logic [65:0] sq;
		r = '0;
		for (int i = 32; i >= 0; i--) begin
			c = r | (33'd1 << i);
			sq = {33'd0, c} * {33'd0, c};
			if (sq <= s) r = c;
		end
		return longint'({31'd0, r});
	endfunction

	function automatic longint magnitude(longint x);
		return x < 0 ? -x : x;
	endfunction

	// One Euler step of a node under the current register mirror.
	function automatic node_update_t step_node(node_beat_t b);
		node_update_t u;
		longint px, py, vx, vy, fx, fy, dx, dy, len, s, tx, ty, v1x, v1y, v2x, v2y, sp;
		logic [65:0] sumsq;
		longint unsigned sv, lim2;
		px = b.pos_x; py = b.pos_y; vx = b.vel_x; vy = b.vel_y;
		fx = 0; fy = 0;
		for (int k = 0; k < 4; k++) begin
			dx = px - longint'(b.nb_x[k]);
			dy = py - longint'(b.nb_y[k]);
			// skip a neighbor that sits on the node
			if (dx == 0 && dy == 0) continue;
			sumsq = {2'b0, 64'(magnitude(dx)) * 64'(magnitude(dx))}
				+ {2'b0, 64'(magnitude(dy)) * 64'(magnitude(dy))};
			len = floor_root(sumsq);
			s = (stiff_m * (rest_len_m - len)) >>> 16;
			if (s > SPRING_CLAMP) s = SPRING_CLAMP;
			if (s < -SPRING_CLAMP) s = -SPRING_CLAMP;
			tx = (dx * 64'sd1073741824) / len;
			ty = (dy * 64'sd1073741824) / len;
			fx += (s * tx) >>> 30;
			fy += (s * ty) >>> 30;
		end
		v1x = sat32(vx + fx);
		v1y = sat32(vy + fy - grav_m);
		sv = longint'(v1x * v1x) + longint'(v1y * v1y);
		lim2 = slim_m * slim_m;
		if (sv > lim2) begin
			sp = floor_root({2'b0, sv});
			v1x = (v1x * slim_m) / sp;
			v1y = (v1y * slim_m) / sp;
		end
		v2x = sat32(v1x - ((damp_m * v1x) >>> 16));
		v2y = sat32(v1y - ((damp_m * v1y) >>> 16));
		u.pos_x = 32'(sat32(px + v2x));
		u.pos_y = 32'(sat32(py + v2y));
		u.vel_x = 32'(v2x);
		u.vel_y = 32'(v2y);
		return u;
	endfunction

	function automatic bit roll_gap(bit is_sender);
		case (idle_mode)
			IDLE_SENDER:   return is_sender && $urandom_range(99) < 62;
			IDLE_RECEIVER: return !is_sender && $urandom_range(99) < 62;
			IDLE_BOTH:     return $urandom_range(99) < 8;
			default:       return 1'b0;
		endcase
	endfunction

	// Driver: hold a beat until it is taken, then predict its update.
	always @(posedge clk) begin
		if (node_in.valid && node_in.ready)
			updates_due.push_back(step_node(beat_on_bus));
		if (!(node_in.valid && !node_in.ready)) begin
			if (beats_waiting.size() > 0 && !roll_gap(1'b1)) begin
				beat_on_bus = beats_waiting.pop_front();
				node_in.pos_x <= beat_on_bus.pos_x;
				node_in.pos_y <= beat_on_bus.pos_y;
				node_in.vel_x <= beat_on_bus.vel_x;
				node_in.vel_y <= beat_on_bus.vel_y;
				node_in.nb1_x <= beat_on_bus.nb_x[0];
				node_in.nb1_y <= beat_on_bus.nb_y[0];
				node_in.nb2_x <= beat_on_bus.nb_x[1];
				node_in.nb2_y <= beat_on_bus.nb_y[1];
				node_in.nb3_x <= beat_on_bus.nb_x[2];
				node_in.nb3_y <= beat_on_bus.nb_y[2];
				node_in.nb4_x <= beat_on_bus.nb_x[3];
				node_in.nb4_y <= beat_on_bus.nb_y[3];
				node_in.valid <= 1'b1;
			end else begin
				node_in.valid <= 1'b0;
			end
		end
	end

	// Receiver: a long hold-off on request, otherwise random stalls per mode.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left <= HOLD_CYCLES;
			node_out.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			node_out.ready <= 1'b0;
		end else begin
			node_out.ready <= !roll_gap(1'b0);
		end
	end

	function automatic void check_field(string name, logic signed [31:0] exp_v,
			logic signed [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Monitor: compare each output beat against the oldest predicted update.
	always @(posedge clk) begin
		node_update_t e;
		if (node_out.valid && node_out.ready) begin
			if (updates_due.size() == 0) begin
				$error("output beat with no update pending");
				errors++;
			end else begin
				e = updates_due.pop_front();
				check_field("new_pos_x", e.pos_x, node_out.new_pos_x);
				check_field("new_pos_y", e.pos_y, node_out.new_pos_y);
				check_field("new_vel_x", e.vel_x, node_out.new_vel_x);
				check_field("new_vel_y", e.vel_y, node_out.new_vel_y);
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("** mass_spring_node_step: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [msns_pkg::CFG_IDX_W-1:0] idx, cfg_word_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			msns_pkg::CFG_REST_LENGTH: rest_len_m = val;
			msns_pkg::CFG_STIFFNESS:   stiff_m = val[msns_pkg::COEF_W-1:0];
			msns_pkg::CFG_GRAVITY:     grav_m = val[msns_pkg::COEF_W-1:0];
			msns_pkg::CFG_DAMPING:     damp_m = val[msns_pkg::COEF_W-1:0];
			msns_pkg::CFG_SPEED_LIMIT: slim_m = val[msns_pkg::SLIM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(int r, int k, int g, int d, int l);
		write_reg(msns_pkg::CFG_REST_LENGTH, cfg_word_t'(r));
		write_reg(msns_pkg::CFG_STIFFNESS, cfg_word_t'(k));
		write_reg(msns_pkg::CFG_GRAVITY, cfg_word_t'(g));
		write_reg(msns_pkg::CFG_DAMPING, cfg_word_t'(d));
		write_reg(msns_pkg::CFG_SPEED_LIMIT, cfg_word_t'(l));
	endtask

	// Wait until every beat went in and every update came back.
	task automatic drain();
		while (beats_waiting.size() > 0 || node_in.valid || updates_due.size() > 0 ||
				hold_left > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [31:0] near(logic signed [31:0] base, int span);
		return base + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	// Mostly a plausible cloth node: neighbors within a few rest lengths,
	// sometimes coincident; the rest is noise over the full field range.
	function automatic node_beat_t random_node();
		node_beat_t b;
		bit noisy;
		noisy = $urandom_range(99) < 25;
		b.pos_x = near(0, 32'h0400_0000);
		b.pos_y = near(0, 32'h0400_0000);
		b.vel_x = near(0, 32'h0006_0000);
		b.vel_y = near(0, 32'h0006_0000);
		for (int k = 0; k < 4; k++) begin
			if ($urandom_range(7) == 0) begin
				b.nb_x[k] = b.pos_x;
				b.nb_y[k] = b.pos_y;
			end else begin
				b.nb_x[k] = near(b.pos_x, 32'h0014_0000);
				b.nb_y[k] = near(b.pos_y, 32'h0014_0000);
			end
		end
		if (noisy) begin
			if ($urandom_range(1)) b.pos_x = $urandom;
			if ($urandom_range(1)) b.pos_y = $urandom;
			if ($urandom_range(1)) b.vel_x = $urandom;
			if ($urandom_range(1)) b.vel_y = $urandom;
			for (int k = 0; k < 4; k++) begin
				if ($urandom_range(1)) b.nb_x[k] = $urandom;
				if ($urandom_range(1)) b.nb_y[k] = $urandom;
			end
		end
		return b;
	endfunction

	task automatic add_random(int count);
		repeat (count) beats_waiting.push_back(random_node());
	endtask

	function automatic node_beat_t make_node(int px, int py, int vx, int vy, int dx, int dy);
		node_beat_t b;
		b.pos_x = px; b.pos_y = py; b.vel_x = vx; b.vel_y = vy;
		b.nb_x[0] = px + dx; b.nb_y[0] = py;
		b.nb_x[1] = px - dx; b.nb_y[1] = py;
		b.nb_x[2] = px;      b.nb_y[2] = py + dy;
		b.nb_x[3] = px;      b.nb_y[3] = py - dy;
		return b;
	endfunction

	task automatic add_directed();
		node_beat_t b;
		localparam int MAXI = 32'sh7fff_ffff;
		localparam int MINI = 32'sh8000_0000;
		// all neighbors on the node: only gravity and damping act
		beats_waiting.push_back(make_node(0, 0, 0, 0, 0, 0));
		beats_waiting.push_back(make_node(MAXI, MINI, 0, 0, 0, 0));
		// springs at rest, stretched, compressed
		beats_waiting.push_back(make_node(0, 0, 0, 0, 32'sh000a_0000, 32'sh000a_0000));
		beats_waiting.push_back(make_node(5 << 16, -3 << 16, 1 << 16, -1 << 16,
			32'sh0014_0000, 32'sh0002_0000));
		beats_waiting.push_back(make_node(0, 0, 0, 0, 1, 1));
		// velocity extremes and position saturation
		beats_waiting.push_back(make_node(MAXI, MAXI, MAXI, MAXI, 0, 0));
		beats_waiting.push_back(make_node(MINI, MINI, MINI, MINI, 0, 0));
		beats_waiting.push_back(make_node(MAXI - 5, MINI + 5, 32'sh0004_0000, -32'sh0004_0000,
			32'sh000c_0000, 32'sh0008_0000));
		// neighbors across the full range: huge spring pull
		b = make_node(MAXI, MAXI, 0, 0, 0, 0);
		b.nb_x = '{MINI, MINI, MAXI, 0};
		b.nb_y = '{MINI, MAXI, MINI, 0};
		beats_waiting.push_back(b);
		b = make_node(MINI, 0, MAXI, MINI, 0, 0);
		b.nb_x = '{MAXI, MAXI, MINI, MINI};
		b.nb_y = '{MAXI, MINI, MAXI, MINI + 1};
		beats_waiting.push_back(b);
		b = make_node(-1, -1, -1, -1, 0, 0);
		b.nb_x = '{0, -1, 1, MINI};
		b.nb_y = '{-1, 0, 1, MAXI};
		beats_waiting.push_back(b);
	endtask

	initial begin
		node_in.valid = 1'b0;
		node_in.pos_x = '0; node_in.pos_y = '0; node_in.vel_x = '0; node_in.vel_y = '0;
		node_in.nb1_x = '0; node_in.nb1_y = '0; node_in.nb2_x = '0; node_in.nb2_y = '0;
		node_in.nb3_x = '0; node_in.nb3_y = '0; node_in.nb4_x = '0; node_in.nb4_y = '0;
		node_out.ready = 1'b0;
		rest_len_m = msns_pkg::REST_RST; stiff_m = msns_pkg::STIFF_RST;
		grav_m = msns_pkg::GRAV_RST; damp_m = msns_pkg::DAMP_RST;
		slim_m = msns_pkg::SLIM_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: directed beats, then a plain burst.
		add_directed();
		add_random(100);
		drain();

		// Receiver holds off for a long stretch so the pipe fills and stalls input.
		write_all(32'h000c_0000, 32'h0000_8000, 32'h0000_0400, 32'h0000_0200, 32'h0008_0000);
		write_reg(CFG_IDX_UNUSED, 27'h7ff_ffff);
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		add_random(300);
		drain();

		// Large values: each register with only its top bit set.
		write_all(67108864, 65536, 65536, 65536, 4194304);
		idle_mode = IDLE_SENDER;
		add_directed();
		add_random(80);
		drain();

		// All zero: zero speed limit, no springs, no damping.
		write_all(0, 0, 0, 0, 0);
		idle_mode = IDLE_RECEIVER;
		add_directed();
		add_random(80);
		drain();

		// Strong springs, tight limit, then back to defaults.
		write_all(32'h0001_0000, 65536, 32'h0000_0100, 32'h0000_1000, 32'h0000_8000);
		idle_mode = IDLE_BOTH;
		add_random(80);
		drain();

		write_all(msns_pkg::REST_RST, msns_pkg::STIFF_RST, msns_pkg::GRAV_RST,
			msns_pkg::DAMP_RST, msns_pkg::SLIM_RST);
		idle_mode = IDLE_SENDER;
		add_random(50);
		drain();
		idle_mode = IDLE_NONE;
		add_random(40);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (updates_due.size() > 0) begin
			$error("%0d updates never arrived", updates_due.size());
			errors++;
		end
		if (errors == 0) begin
			$display("** mass_spring_node_step: PASSED **");
		end else begin
			$display("** mass_spring_node_step: FAILED **");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/msns_pkg.sv
src/msns_if.sv
src/msns_normdiv.sv
src/mass_spring_node_step.sv
tb/tb_top.sv
